// ===== src/imusd_pkg.sv =====
// Shared constants, command/status types and the arctangent table of the stillness detector.
package imusd_pkg;

  // Sample and CORDIC sizing
  localparam int SAMPLE_BITS   = 16;
  localparam int CORDIC_STEPS  = 14;
  localparam int CORDIC_ITERS  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int GUARD_SHIFT   = 8;
  localparam int IN_W          = 16;
  localparam int CFG_W         = 16;
  localparam int ANGLE_W       = 16;
  localparam int AXES          = 6;
  localparam int AXIS_W        = $clog2(AXES);
  localparam int STEP_MAX      = (CORDIC_ITERS > AXES) ? CORDIC_ITERS : AXES;
  localparam int IDX_W         = $clog2(STEP_MAX);

  // Datapath widths
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int CMP_W  = (DIFF_W > CFG_W) ? DIFF_W : CFG_W;
  localparam int CW     = SAMPLE_BITS + 1 + GUARD_SHIFT + 3;
  localparam int ZW     = 35;
  localparam int RSHIFT = 17;
  localparam int RQ_W   = ZW - RSHIFT;

  localparam logic signed [ZW-1:0]   Z_PI      = ZW'(64'sd3373259426);
  localparam logic signed [ZW-1:0]   Z_ROUND   = ZW'(65536);
  localparam logic signed [RQ_W-1:0] ANG_MAX   = RQ_W'(25736);
  localparam logic signed [RQ_W-1:0] ANG_MIN   = RQ_W'(-25736);

  // Operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL  = 2'd2;

  // Configuration reset values
  localparam logic [CFG_W-1:0] PERIOD_RST = CFG_W'(1000);
  localparam logic [CFG_W-1:0] MOTION_RST = CFG_W'(3 * 1024);
  localparam logic [CFG_W-1:0] LEVEL_RST  = CFG_W'(3 * 1024);

  // Controller to datapath commands
  typedef struct packed {
    logic             capture;
    logic             axis_step;
    logic             sample_end;
    logic             tick;
    logic             cordic_step;
    logic             cordic_fin;
    logic             load_out;
    logic [IDX_W-1:0] idx;
  } imusd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cordic_go;
    logic motion;
  } imusd_sts_t;

  // atan(2^-i) in Q2.30, rounded to nearest
  function automatic logic [31:0] atan_q30(input logic [IDX_W-1:0] i);
    logic [31:0] v;
    case (5'(i))
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043837;
      5'd3:  v = 32'd133525159;
      5'd4:  v = 32'd67021687;
      5'd5:  v = 32'd33543516;
      5'd6:  v = 32'd16775851;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194283;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048576;
      5'd11: v = 32'd524288;
      5'd12: v = 32'd262144;
      5'd13: v = 32'd131072;
      5'd14: v = 32'd65536;
      5'd15: v = 32'd32768;
      5'd16: v = 32'd16384;
      5'd17: v = 32'd8192;
      5'd18: v = 32'd4096;
      5'd19: v = 32'd2048;
      5'd20: v = 32'd1024;
      5'd21: v = 32'd512;
      5'd22: v = 32'd256;
      5'd23: v = 32'd128;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Take the low sample bits of a raw port value, zero filling above the port
  function automatic logic signed [SAMPLE_BITS-1:0] take_sample(input logic [IN_W-1:0] raw);
    logic signed [SAMPLE_BITS-1:0] s;
    for (int b = 0; b < SAMPLE_BITS; b++) begin
      s[b] = (b < IN_W) ? raw[b] : 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== src/imusd_dp.sv =====
// Datapath of the stillness detector: configuration, sample store, countdown, CORDIC and output.
module imusd_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [imusd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [imusd_pkg::CFG_W-1:0]   cfg_data,
  input  logic [imusd_pkg::IN_W-1:0]    in_accel_x,
  input  logic [imusd_pkg::IN_W-1:0]    in_accel_y,
  input  logic [imusd_pkg::IN_W-1:0]    in_accel_z,
  input  logic [imusd_pkg::IN_W-1:0]    in_gyro_x,
  input  logic [imusd_pkg::IN_W-1:0]    in_gyro_y,
  input  logic [imusd_pkg::IN_W-1:0]    in_gyro_z,
  input  imusd_pkg::imusd_cmd_t         cmd,
  output imusd_pkg::imusd_sts_t         sts,
  output logic                          out_inactive,
  output logic                          out_still_and_level,
  output logic signed [imusd_pkg::ANGLE_W-1:0] out_row_angle
);
  import imusd_pkg::*;

  logic [CFG_W-1:0] period_r, motion_thr_r, level_thr_r;
  logic signed [SAMPLE_BITS-1:0] smp_r [AXES];
  logic signed [SAMPLE_BITS-1:0] prev_r [AXES];
  logic signed [SAMPLE_BITS-1:0] prev_nxt [AXES];
  logic motion_r, motion_nxt;
  logic inactive_r, inactive_nxt;
  logic horiz_r, horiz_nxt;
  logic armed_r, armed_nxt;
  logic [CFG_W-1:0] ticks_r, ticks_nxt;
  logic signed [ANGLE_W-1:0] angle_r, angle_nxt;
  logic signed [CW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [ZW-1:0] cz_r, cz_nxt;
  logic zero_r, zero_nxt;
  logic out_inactive_r, out_level_r;
  logic signed [ANGLE_W-1:0] out_angle_r;

  logic [AXIS_W-1:0] axis;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] diff_mag;
  logic axis_motion;
  logic [CFG_W-1:0] period_eff;
  logic signed [DIFF_W-1:0] ay_ext;
  logic [DIFF_W-1:0] ay_mag;
  logic level;
  logic [CFG_W-1:0] ticks_dec;
  logic expire;
  logic signed [DIFF_W-1:0] yin;
  logic signed [SAMPLE_BITS-1:0] xin;
  logic signed [CW-1:0] x0, y0, xs, ys;
  logic signed [ZW-1:0] atan_v, z_round;
  logic signed [RQ_W-1:0] rq, rq_sat;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= PERIOD_RST;
      motion_thr_r <= MOTION_RST;
      level_thr_r  <= LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD: period_r     <= cfg_data;
        REG_MOTION: motion_thr_r <= cfg_data;
        REG_LEVEL:  level_thr_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the sample beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp_r[0] <= take_sample(in_accel_x);
      smp_r[1] <= take_sample(in_accel_y);
      smp_r[2] <= take_sample(in_accel_z);
      smp_r[3] <= take_sample(in_gyro_x);
      smp_r[4] <= take_sample(in_gyro_y);
      smp_r[5] <= take_sample(in_gyro_z);
    end
  end

  // Difference one axis per cycle against the previous sample
  assign axis        = cmd.idx[AXIS_W-1:0];
  assign diff        = DIFF_W'(smp_r[axis]) - DIFF_W'(prev_r[axis]);
  assign diff_mag    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign axis_motion = CMP_W'(diff_mag) >= CMP_W'(motion_thr_r);

  // Countdown and level decisions
  assign period_eff = (period_r == '0) ? CFG_W'(1) : period_r;
  assign ay_ext     = DIFF_W'(prev_r[1]);
  assign ay_mag     = ay_ext[DIFF_W-1] ? DIFF_W'(-ay_ext) : DIFF_W'(ay_ext);
  assign level      = CMP_W'(ay_mag) < CMP_W'(level_thr_r);
  assign ticks_dec  = (ticks_r == '0) ? ticks_r : ticks_r - CFG_W'(1);
  assign expire     = armed_r && (ticks_dec == '0);

  assign sts.cordic_go = expire && level;
  assign sts.motion    = motion_r;

  // CORDIC operands: vector (accel_z, -accel_x) scaled by the guard shift
  assign xin = prev_r[2];
  assign yin = -DIFF_W'(prev_r[0]);
  assign x0  = CW'(xin) <<< GUARD_SHIFT;
  assign y0  = CW'(yin) <<< GUARD_SHIFT;
  assign xs  = cx_r >>> cmd.idx;
  assign ys  = cy_r >>> cmd.idx;
  assign atan_v = signed'(ZW'(atan_q30(cmd.idx)));

  // Round Q2.30 to Q3.13 and saturate
  assign z_round = cz_r + Z_ROUND;
  assign rq      = z_round[ZW-1:RSHIFT];
  always_comb begin
    if (rq > ANG_MAX) begin
      rq_sat = ANG_MAX;
    end else if (rq < ANG_MIN) begin
      rq_sat = ANG_MIN;
    end else begin
      rq_sat = rq;
    end
  end

  // Next state of the detector
  always_comb begin
    prev_nxt     = prev_r;
    motion_nxt   = motion_r;
    inactive_nxt = inactive_r;
    horiz_nxt    = horiz_r;
    armed_nxt    = armed_r;
    ticks_nxt    = ticks_r;
    angle_nxt    = angle_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    cz_nxt       = cz_r;
    zero_nxt     = zero_r;

    if (cmd.capture) begin
      motion_nxt = 1'b0;
    end

    if (cmd.axis_step) begin
      prev_nxt[axis] = smp_r[axis];
      if (axis_motion) begin
        motion_nxt = 1'b1;
      end
    end

    // Restart the countdown on motion and leave the inactive state
    if (cmd.sample_end && motion_r) begin
      armed_nxt = 1'b1;
      ticks_nxt = period_eff;
      if (inactive_r) begin
        inactive_nxt = 1'b0;
        horiz_nxt    = 1'b0;
      end
    end

    // Advance the countdown; expire turns the block inactive
    if (cmd.tick && armed_r) begin
      ticks_nxt = ticks_dec;
      if (expire) begin
        inactive_nxt = 1'b1;
        horiz_nxt    = level;
        if (level) begin
          armed_nxt = 1'b0;
          ticks_nxt = '0;
          zero_nxt  = (xin == '0) && (yin == '0);
          if (xin < 0) begin
            cx_nxt = -x0;
            cy_nxt = -y0;
            cz_nxt = (yin >= 0) ? Z_PI : -Z_PI;
          end else begin
            cx_nxt = x0;
            cy_nxt = y0;
            cz_nxt = '0;
          end
        end else begin
          armed_nxt = 1'b1;
          ticks_nxt = period_eff;
        end
      end
    end

    // One vectoring rotation
    if (cmd.cordic_step) begin
      if (cy_r >= 0) begin
        cx_nxt = cx_r + ys;
        cy_nxt = cy_r - xs;
        cz_nxt = cz_r + atan_v;
      end else begin
        cx_nxt = cx_r - ys;
        cy_nxt = cy_r + xs;
        cz_nxt = cz_r - atan_v;
      end
    end

    if (cmd.cordic_fin) begin
      angle_nxt = zero_r ? '0 : rq_sat[ANGLE_W-1:0];
    end
  end

  // Detector state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        prev_r[a] <= '0;
      end
      motion_r   <= 1'b0;
      inactive_r <= 1'b0;
      horiz_r    <= 1'b0;
      armed_r    <= 1'b0;
      ticks_r    <= '0;
      angle_r    <= '0;
    end else begin
      prev_r     <= prev_nxt;
      motion_r   <= motion_nxt;
      inactive_r <= inactive_nxt;
      horiz_r    <= horiz_nxt;
      armed_r    <= armed_nxt;
      ticks_r    <= ticks_nxt;
      angle_r    <= angle_nxt;
    end
  end

  // CORDIC working registers
  always_ff @(posedge clk) begin
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    cz_r   <= cz_nxt;
    zero_r <= zero_nxt;
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_inactive_r <= inactive_r;
      out_level_r    <= inactive_r && horiz_r;
      out_angle_r    <= angle_r;
    end
  end

  assign out_inactive        = out_inactive_r;
  assign out_still_and_level = out_level_r;
  assign out_row_angle       = out_angle_r;

endmodule

// ===== src/imusd_ctrl.sv =====
// Controller of the stillness detector: sequences axis compares, ticks, CORDIC steps and output.
module imusd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_operation,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  imusd_pkg::imusd_sts_t sts,
  output imusd_pkg::imusd_cmd_t cmd
);
  import imusd_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_AXIS    = 7'b0000010,
    ST_SMP_END = 7'b0000100,
    ST_TICK    = 7'b0001000,
    ST_CORDIC  = 7'b0010000,
    ST_FIN     = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  // Sequence one beat at a time
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = cnt_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = (in_operation == OP_TICK) ? ST_TICK : ST_AXIS;
        end
      end
      ST_AXIS: begin
        cmd.axis_step = 1'b1;
        if (cnt_r == IDX_W'(AXES - 1)) begin
          state_nxt = ST_SMP_END;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_SMP_END: begin
        cmd.sample_end = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_TICK: begin
        cmd.tick = 1'b1;
        cnt_nxt  = '0;
        state_nxt = sts.cordic_go ? ST_CORDIC : ST_DONE;
      end
      ST_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (cnt_r == IDX_W'(CORDIC_ITERS - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_FIN: begin
        cmd.cordic_fin = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the result beat until taken
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result beat overwritten before it was taken");

  // A tick beat goes straight to the countdown update
  a_tick_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation == OP_TICK) |=> state_r == ST_TICK)
    else $error("tick beat did not reach the countdown update");

  // Axis counter stays within the six axes
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_AXIS |-> cnt_r < IDX_W'(AXES))
    else $error("axis index out of range");

  // CORDIC runs exactly its step count before finishing
  a_cordic_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CORDIC && cnt_r != IDX_W'(CORDIC_ITERS - 1)) |=> state_r == ST_CORDIC)
    else $error("CORDIC left early");

  // The angle is written only after the CORDIC steps
  a_fin_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |-> $past(state_r) == ST_CORDIC)
    else $error("angle written without CORDIC steps");

endmodule

// ===== src/imu_stillness_detector_top.sv =====
// Top level of the IMU stillness detector: controller plus datapath.
//
// Input channel (in_valid/in_ready): one beat is either a six-axis sample
// (in_operation = 0) or a one millisecond tick (in_operation = 1).
// Result channel (out_valid/out_ready): exactly one beat per input beat,
// carrying the inactive flag, the still-and-level flag and the last roll
// angle in signed Q3.13 radians.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 period in ms, 1 motion threshold, 2 level threshold); the user
// writes only while idle, and the block itself does not enforce it.
// A sample is processed with one compare per axis; a tick advances the
// countdown, and when it expires level the CORDIC runs its 14 rotation
// steps on one shared shift/add unit.
// One beat is in work at a time; the next beat is accepted while the last
// result still waits in the output register.
// Reset (synchronous, rst_n low) clears the flags, countdown, angle and
// previous sample and restores the default register values.
// A stalled receiver holds the result; processing of the following beat
// completes and then waits until the output register is free.
module imu_stillness_detector_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [imusd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [imusd_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_operation,
  input  logic signed [imusd_pkg::IN_W-1:0]    in_accel_x,
  input  logic signed [imusd_pkg::IN_W-1:0]    in_accel_y,
  input  logic signed [imusd_pkg::IN_W-1:0]    in_accel_z,
  input  logic signed [imusd_pkg::IN_W-1:0]    in_gyro_x,
  input  logic signed [imusd_pkg::IN_W-1:0]    in_gyro_y,
  input  logic signed [imusd_pkg::IN_W-1:0]    in_gyro_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_inactive,
  output logic                                 out_still_and_level,
  output logic signed [imusd_pkg::ANGLE_W-1:0] out_row_angle
);
  import imusd_pkg::*;

  imusd_cmd_t cmd;
  imusd_sts_t sts;

  // Sequence the work
  imusd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Compute flags, countdown and angle
  imusd_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_accel_x          (in_accel_x),
    .in_accel_y          (in_accel_y),
    .in_accel_z          (in_accel_z),
    .in_gyro_x           (in_gyro_x),
    .in_gyro_y           (in_gyro_y),
    .in_gyro_z           (in_gyro_z),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_inactive        (out_inactive),
    .out_still_and_level (out_still_and_level),
    .out_row_angle       (out_row_angle)
  );

endmodule
